[rtl/csv_line_field_splitter_defines.svh]
// Assertion macros for the CSV line field splitter.
// Each macro checks a property on the rising edge of clk, disabled during reset.
`ifndef CSV_LINE_FIELD_SPLITTER_DEFINES_SVH
`define CSV_LINE_FIELD_SPLITTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CSV_ASSERT_SAME(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("csv splitter check failed");
`define CSV_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("csv splitter check failed");
`else
`define CSV_ASSERT_SAME(label, cond, conseq)
`define CSV_ASSERT_NEXT(label, cond, conseq)
`endif

`endif

[rtl/csv_lfs_pkg.sv]
package csv_lfs_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] INDEX_MAX = 8'hFF;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_FIELD_END = 1'b1;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_line;
    } in_beat_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] field_index;
        logic       line_done;
    } out_beat_t;

    typedef struct packed {
        logic       in_quotes;
        logic       quote_pending;
        logic       field_nonempty;
        logic [7:0] field_counter;
    } parse_state_t;

endpackage

[rtl/csv_lfs_in_stage.sv]
module csv_lfs_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  csv_lfs_pkg::in_beat_t beat,
    input  logic                 advance,
    output logic                 fire,
    output csv_lfs_pkg::in_beat_t hold_beat
);

    logic                  valid_reg;
    logic                  valid_next;
    csv_lfs_pkg::in_beat_t beat_reg;
    logic                  accept;

    assign char_ready = !valid_reg || advance;
    assign accept     = char_valid && char_ready;
    assign fire       = valid_reg && advance;
    assign hold_beat  = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= beat;
        end
    end

endmodule

[rtl/csv_lfs_parse.sv]
module csv_lfs_parse (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  csv_lfs_pkg::in_beat_t     beat,
    output logic                      res_valid,
    output csv_lfs_pkg::out_beat_t    res,
    output csv_lfs_pkg::parse_state_t status
);

    csv_lfs_pkg::parse_state_t state_reg;
    csv_lfs_pkg::parse_state_t state_next;
    logic                      is_quote;
    logic                      is_comma;
    logic                      unquoted;

    assign is_quote = (beat.char_in == csv_lfs_pkg::CH_QUOTE);
    assign is_comma = (beat.char_in == csv_lfs_pkg::CH_COMMA);
    assign status   = state_reg;

    always_comb
    begin
        state_next      = state_reg;
        unquoted        = 1'b0;
        res_valid       = 1'b0;
        res.kind        = csv_lfs_pkg::KIND_DATA;
        res.data_byte   = beat.char_in;
        res.field_index = state_reg.field_counter;
        res.line_done   = 1'b0;

        if (beat.end_of_line)
        begin
            res_valid     = 1'b1;
            res.kind      = csv_lfs_pkg::KIND_FIELD_END;
            res.data_byte = 8'd0;
            res.line_done = 1'b1;
            state_next    = '0;
        end
        else if (state_reg.quote_pending)
        begin
            state_next.quote_pending = 1'b0;
            if (is_quote)
            begin
                state_next.field_nonempty = 1'b1;
                res_valid                 = 1'b1;
            end
            else
            begin
                state_next.in_quotes = 1'b0;
                unquoted             = 1'b1;
            end
        end
        else if (state_reg.in_quotes)
        begin
            if (is_quote)
            begin
                state_next.quote_pending = 1'b1;
            end
            else
            begin
                state_next.field_nonempty = 1'b1;
                res_valid                 = 1'b1;
            end
        end
        else
        begin
            unquoted = 1'b1;
        end

        if (unquoted)
        begin
            if (is_quote && !state_reg.field_nonempty)
            begin
                state_next.in_quotes = 1'b1;
            end
            else if (is_comma)
            begin
                res_valid                 = 1'b1;
                res.kind                  = csv_lfs_pkg::KIND_FIELD_END;
                res.data_byte             = 8'd0;
                state_next.field_nonempty = 1'b0;
                if (state_reg.field_counter != csv_lfs_pkg::INDEX_MAX)
                begin
                    state_next.field_counter = state_reg.field_counter + 8'd1;
                end
            end
            else
            begin
                state_next.field_nonempty = 1'b1;
                res_valid                 = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/csv_lfs_out_stage.sv]
module csv_lfs_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  csv_lfs_pkg::out_beat_t res,
    output logic                   slot_free,
    output logic                   field_valid,
    input  logic                   field_ready,
    output csv_lfs_pkg::out_beat_t beat
);

    logic                   valid_reg;
    logic                   valid_next;
    csv_lfs_pkg::out_beat_t beat_reg;

    assign slot_free   = !valid_reg || field_ready;
    assign field_valid = valid_reg;
    assign beat        = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (field_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= res;
        end
    end

endmodule

[rtl/csv_line_field_splitter.sv]
// Channel  Handshake                 Payload
// char     char_valid / char_ready   char_in, end_of_line
// field    field_valid / field_ready kind, data_byte, field_index, line_done
//
// One beat is accepted per cycle unless a stalled result blocks the input stage; each beat is
// registered in the input stage, parsed combinationally and its result held in the output register.
// A byte that produces no result (an opening or pending quote) only updates parser state.
// Reset clears all parser state and both stage valid flags; no memory needs clearing.
// A stalled result holds its register; the input stage can still take one more beat if it is empty.
`include "csv_line_field_splitter_defines.svh"

module csv_line_field_splitter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  logic [7:0] char_in,
    input  logic       end_of_line,
    output logic       field_valid,
    input  logic       field_ready,
    output logic       kind,
    output logic [7:0] data_byte,
    output logic [7:0] field_index,
    output logic       line_done
);

    csv_lfs_pkg::in_beat_t     in_beat;
    csv_lfs_pkg::in_beat_t     hold_beat;
    csv_lfs_pkg::out_beat_t    res;
    csv_lfs_pkg::out_beat_t    out_beat;
    csv_lfs_pkg::parse_state_t status;
    logic                      advance;
    logic                      fire;
    logic                      res_valid;
    logic                      load;
    logic                      at_max;

    assign in_beat.char_in     = char_in;
    assign in_beat.end_of_line = end_of_line;
    assign load                = fire && res_valid;
    assign at_max              = (status.field_counter == csv_lfs_pkg::INDEX_MAX);

    csv_lfs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .beat       (in_beat),
        .advance    (advance),
        .fire       (fire),
        .hold_beat  (hold_beat)
    );

    csv_lfs_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .beat      (hold_beat),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    csv_lfs_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .res         (res),
        .slot_free   (advance),
        .field_valid (field_valid),
        .field_ready (field_ready),
        .beat        (out_beat)
    );

    assign kind        = out_beat.kind;
    assign data_byte   = out_beat.data_byte;
    assign field_index = out_beat.field_index;
    assign line_done   = out_beat.line_done;

    `CSV_ASSERT_SAME(a_pending_in_quotes, status.quote_pending, status.in_quotes)
    `CSV_ASSERT_NEXT(a_eol_clears, fire && hold_beat.end_of_line, status == '0)
    `CSV_ASSERT_NEXT(a_index_saturates, fire && !hold_beat.end_of_line && at_max, at_max)

endmodule

[tb/tb_csv_line_field_splitter.sv]
module tb_csv_line_field_splitter;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 1150;
    localparam int SAT_LINE_FIELDS = 262;
    localparam int PRINT_LIMIT = 40;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       char_valid = 1'b0;
    logic       char_ready;
    logic [7:0] char_in = 8'h00;
    logic       end_of_line = 1'b0;
    logic       field_valid;
    logic       field_ready = 1'b0;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] field_index;
    logic       line_done;

    csv_line_field_splitter DUT (
        .clk(clk),
        .rst_n(rst_n),
        .char_valid(char_valid),
        .char_ready(char_ready),
        .char_in(char_in),
        .end_of_line(end_of_line),
        .field_valid(field_valid),
        .field_ready(field_ready),
        .kind(kind),
        .data_byte(data_byte),
        .field_index(field_index),
        .line_done(line_done)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    csv_lfs_pkg::in_beat_t  pending_chars[$];
    csv_lfs_pkg::out_beat_t expected_fields[$];
    csv_lfs_pkg::out_beat_t oldest_field;
    csv_lfs_pkg::in_beat_t  next_char;

    logic       in_quoted = 1'b0;
    logic       quote_seen = 1'b0;
    logic       field_open = 1'b0;
    logic [7:0] field_count = 8'h00;

    int  total_items = 0;
    int  items_sent = 0;
    int  fields_checked = 0;
    int  lines_seen = 0;
    int  field_ends_seen = 0;
    int  saturated_ends = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  send_idle = 0;
    int  recv_stall = 0;
    int  calm_timer = 0;
    logic calm = 1'b0;
    logic accepted;

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Predicts the result of one accepted beat and updates the parser state.
    function automatic void split_step(input logic [7:0] ch, input logic eol);
        csv_lfs_pkg::out_beat_t res;
        logic                   produce;
        logic                   plain;
        res = '0;
        res.field_index = field_count;
        produce = 1'b0;
        plain = 1'b0;
        if (eol)
        begin
            res.kind = csv_lfs_pkg::KIND_FIELD_END;
            res.line_done = 1'b1;
            produce = 1'b1;
            in_quoted = 1'b0;
            quote_seen = 1'b0;
            field_open = 1'b0;
            field_count = 8'h00;
        end
        else if (quote_seen)
        begin
            quote_seen = 1'b0;
            if (ch == csv_lfs_pkg::CH_QUOTE)
            begin
                field_open = 1'b1;
                res.kind = csv_lfs_pkg::KIND_DATA;
                res.data_byte = csv_lfs_pkg::CH_QUOTE;
                produce = 1'b1;
            end
            else
            begin
                in_quoted = 1'b0;
                plain = 1'b1;
            end
        end
        else if (in_quoted)
        begin
            if (ch == csv_lfs_pkg::CH_QUOTE)
            begin
                quote_seen = 1'b1;
            end
            else
            begin
                field_open = 1'b1;
                res.kind = csv_lfs_pkg::KIND_DATA;
                res.data_byte = ch;
                produce = 1'b1;
            end
        end
        else
        begin
            plain = 1'b1;
        end
        if (plain)
        begin
            if (ch == csv_lfs_pkg::CH_QUOTE && !field_open)
            begin
                in_quoted = 1'b1;
            end
            else if (ch == csv_lfs_pkg::CH_COMMA)
            begin
                res.kind = csv_lfs_pkg::KIND_FIELD_END;
                produce = 1'b1;
                field_open = 1'b0;
                if (field_count != csv_lfs_pkg::INDEX_MAX)
                    field_count = field_count + 8'd1;
            end
            else
            begin
                field_open = 1'b1;
                res.kind = csv_lfs_pkg::KIND_DATA;
                res.data_byte = ch;
                produce = 1'b1;
            end
        end
        if (produce)
            expected_fields = {expected_fields, res};
    endfunction

    task automatic push_char(input logic [7:0] ch);
        csv_lfs_pkg::in_beat_t b;
        b.char_in = ch;
        b.end_of_line = 1'b0;
        pending_chars = {pending_chars, b};
    endtask

    task automatic push_line_end();
        csv_lfs_pkg::in_beat_t b;
        b.char_in = 8'($urandom_range(0, 255));
        b.end_of_line = 1'b1;
        pending_chars = {pending_chars, b};
    endtask

    task automatic push_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            push_char(s[k]);
    endtask

    function automatic logic [7:0] biased_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return csv_lfs_pkg::CH_QUOTE;
        else if (r == 1)
            return csv_lfs_pkg::CH_COMMA;
        return 8'($urandom_range(0, 255));
    endfunction

    // Random line of unquoted, quoted and empty fields, not always well-formed.
    task automatic push_csv_line();
        int         n_fields;
        int         f;
        int         k;
        int         style;
        int         flen;
        logic [7:0] b;
        n_fields = $urandom_range(1, 6);
        for (f = 0; f < n_fields; f++)
        begin
            if (f > 0)
                push_char(csv_lfs_pkg::CH_COMMA);
            style = $urandom_range(0, 9);
            flen = $urandom_range(0, 6);
            if (style >= 1 && style < 5)
            begin
                for (k = 0; k <= flen; k++)
                begin
                    b = biased_byte();
                    while (b == csv_lfs_pkg::CH_COMMA || (k == 0 && b == csv_lfs_pkg::CH_QUOTE))
                        b = 8'($urandom_range(0, 255));
                    push_char(b);
                end
            end
            else if (style >= 5)
            begin
                push_char(csv_lfs_pkg::CH_QUOTE);
                for (k = 0; k < flen; k++)
                begin
                    b = biased_byte();
                    if (b == csv_lfs_pkg::CH_QUOTE)
                        push_char(csv_lfs_pkg::CH_QUOTE);
                    push_char(b);
                end
                push_char(csv_lfs_pkg::CH_QUOTE);
                if ($urandom_range(0, 7) == 0)
                    push_char(8'($urandom_range(0, 255)));
            end
        end
        push_line_end();
    endtask

    // Random bytes heavy in quotes and commas, sometimes without a line end.
    task automatic push_noise();
        int n;
        int k;
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++)
            push_char(biased_byte());
        if ($urandom_range(0, 3) != 0)
            push_line_end();
    endtask

    initial
    begin
        int  k;
        int  r;
        logic sat_done;
        sat_done = 1'b0;

        push_line_end();
        push_text("\"a\"\"\",x\"");
        push_line_end();
        push_text("\"x\"y,\"q\"");
        push_line_end();
        push_char(csv_lfs_pkg::CH_QUOTE);
        push_char(8'h00);
        push_char(8'hFF);
        push_line_end();

        while (pending_chars.size() < RANDOM_ITEMS)
        begin
            if (!sat_done && pending_chars.size() > RANDOM_ITEMS / 3)
            begin
                for (k = 0; k < SAT_LINE_FIELDS; k++)
                begin
                    if (k % 16 == 5)
                        push_char(8'h41 + k[4:0]);
                    push_char(csv_lfs_pkg::CH_COMMA);
                end
                push_line_end();
                sat_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 78)
                push_csv_line();
            else
                push_noise();
        end
        total_items = pending_chars.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (items_sent != total_items || expected_fields.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d beats over %0d lines; checked %0d result beats (%0d field ends).",
                 items_sent, lines_seen, fields_checked, field_ends_seen);
        $display("Field ends at the saturated index: %0d; mismatches: %0d.",
                 saturated_ends, error_count);
        if (error_count == 0)
            $display("csv_line_field_splitter regression: pass");
        else
            $display("csv_line_field_splitter regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (calm_timer == 0)
        begin
            calm <= ~calm;
            calm_timer <= calm ? $urandom_range(20, 120) : $urandom_range(40, 300);
        end
        else
        begin
            calm_timer <= calm_timer - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            accepted = char_valid && char_ready;
            if (accepted)
            begin
                split_step(char_in, end_of_line);
                items_sent++;
            end
            if (!char_valid || accepted)
            begin
                if (send_idle > 0)
                begin
                    send_idle--;
                    char_valid <= 1'b0;
                end
                else if (pending_chars.size() > 0)
                begin
                    next_char = pending_chars.pop_front();
                    char_in <= next_char.char_in;
                    end_of_line <= next_char.end_of_line;
                    char_valid <= 1'b1;
                    send_idle = pick_gap(calm);
                end
                else
                begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (recv_stall > 0)
            begin
                recv_stall--;
                field_ready <= 1'b0;
            end
            else
            begin
                field_ready <= 1'b1;
                recv_stall = pick_gap(calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && field_valid === 1'b1 && field_ready)
        begin
            fields_checked++;
            if (kind === csv_lfs_pkg::KIND_FIELD_END)
                field_ends_seen++;
            if (line_done === 1'b1)
                lines_seen++;
            if (kind === csv_lfs_pkg::KIND_FIELD_END && field_index === csv_lfs_pkg::INDEX_MAX)
                saturated_ends++;
            if (expected_fields.size() == 0)
            begin
                report_mismatch("result beat with no expectation waiting");
            end
            else
            begin
                oldest_field = expected_fields.pop_front();
                if (kind !== oldest_field.kind)
                    report_mismatch($sformatf("kind %b, expected %b",
                                              kind, oldest_field.kind));
                if (data_byte !== oldest_field.data_byte)
                    report_mismatch($sformatf("data_byte %h, expected %h",
                                              data_byte, oldest_field.data_byte));
                if (field_index !== oldest_field.field_index)
                    report_mismatch($sformatf("field_index %0d, expected %0d",
                                              field_index, oldest_field.field_index));
                if (line_done !== oldest_field.line_done)
                    report_mismatch($sformatf("line_done %b, expected %b",
                                              line_done, oldest_field.line_done));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d of %0d beats sent.",
                     cycle_count, items_sent, total_items);
            $display("csv_line_field_splitter regression: fail");
            $finish;
        end
    end

endmodule

[sim.f]
+incdir+rtl
rtl/csv_lfs_pkg.sv
rtl/csv_lfs_in_stage.sv
rtl/csv_lfs_parse.sv
rtl/csv_lfs_out_stage.sv
rtl/csv_line_field_splitter.sv
tb/tb_csv_line_field_splitter.sv
